@@ hw/rtl/fmia_pkg.sv @@
// Package for the Fock matrix integral accumulator: item types, sequencer states,
// update schedule table and shared helper functions. No dependencies.
package fmia_pkg;

  localparam int MAX_BASIS = 32;
  localparam int IDX_W     = $clog2(MAX_BASIS);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int CFG_W     = 6;
  localparam int WORD_W    = 64;
  localparam int STEP_W    = 4;

  localparam logic [WORD_W-1:0] SIGN_WORD = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] POS_MAX   = {1'b0, {(WORD_W-1){1'b1}}};

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_INTEGRAL = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [4:0]        index_i;
    logic [4:0]        index_j;
    logic [4:0]        index_k;
    logic [4:0]        index_l;
    logic signed [63:0] integral_value;
    logic signed [63:0] density_value;
    logic signed [63:0] core_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] fock_value;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_WAIT,
    ST_FETCH,
    ST_MAG,
    ST_TERM,
    ST_ADD
  } state_t;

  typedef enum logic [2:0] {
    SCH_SINGLE,
    SCH_THREE,
    SCH_PAIR_A,
    SCH_PAIR_B,
    SCH_TWO_A,
    SCH_TWO_B,
    SCH_DISTINCT
  } scheme_t;

  // One update: destination role pair, density role pair, weight and end mark.
  typedef struct packed {
    logic [1:0] rs;
    logic [1:0] cs;
    logic [1:0] ps;
    logic [1:0] qs;
    logic [2:0] mag;
    logic       neg;
    logic       last;
  } update_entry_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dmag;
    logic [WORD_W-1:0] tmag;
    logic [2:0]        mag;
    logic              neg;
  } term_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] term;
    logic              sat;
  } term_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } dens_wr_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W:0]   data;
  } fock_wr_t;

  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic update_entry_t mk(input logic [1:0] rs, input logic [1:0] cs,
                                       input logic [1:0] ps, input logic [1:0] qs,
                                       input logic [2:0] mag, input logic neg,
                                       input logic last);
    update_entry_t e;
    e.rs = rs; e.cs = cs; e.ps = ps; e.qs = qs;
    e.mag = mag; e.neg = neg; e.last = last;
    return e;
  endfunction

  // Fixed update order per scheme; roles are 0..3 as set at classification.
  function automatic update_entry_t update_entry(input scheme_t sch,
                                                 input logic [STEP_W-1:0] step);
    update_entry_t e;
    e = mk(2'd0, 2'd0, 2'd0, 2'd0, 3'd1, 1'b0, 1'b1);
    unique case (sch)
      SCH_SINGLE: e = mk(2'd0, 2'd0, 2'd0, 2'd0, 3'd1, 1'b0, 1'b1);
      SCH_THREE: begin
        unique case (step)
          4'd0:    e = mk(2'd0, 2'd0, 2'd0, 2'd1, 3'd2, 1'b0, 1'b0);
          4'd1:    e = mk(2'd0, 2'd1, 2'd0, 2'd0, 3'd1, 1'b0, 1'b0);
          default: e = mk(2'd1, 2'd0, 2'd0, 2'd0, 3'd1, 1'b0, 1'b1);
        endcase
      end
      SCH_PAIR_A: begin
        unique case (step)
          4'd0:    e = mk(2'd0, 2'd0, 2'd1, 2'd1, 3'd2, 1'b0, 1'b0);
          4'd1:    e = mk(2'd1, 2'd1, 2'd0, 2'd0, 3'd2, 1'b0, 1'b0);
          4'd2:    e = mk(2'd0, 2'd1, 2'd0, 2'd1, 3'd1, 1'b1, 1'b0);
          default: e = mk(2'd1, 2'd0, 2'd1, 2'd0, 3'd1, 1'b1, 1'b1);
        endcase
      end
      SCH_PAIR_B: begin
        unique case (step)
          4'd0:    e = mk(2'd0, 2'd1, 2'd0, 2'd1, 3'd3, 1'b0, 1'b0);
          4'd1:    e = mk(2'd1, 2'd0, 2'd0, 2'd1, 3'd3, 1'b0, 1'b0);
          4'd2:    e = mk(2'd0, 2'd0, 2'd1, 2'd1, 3'd1, 1'b1, 1'b0);
          default: e = mk(2'd1, 2'd1, 2'd0, 2'd0, 3'd1, 1'b1, 1'b1);
        endcase
      end
      SCH_TWO_A: begin
        unique case (step)
          4'd0:    e = mk(2'd0, 2'd0, 2'd1, 2'd2, 3'd4, 1'b0, 1'b0);
          4'd1:    e = mk(2'd1, 2'd2, 2'd0, 2'd0, 3'd2, 1'b0, 1'b0);
          4'd2:    e = mk(2'd2, 2'd1, 2'd0, 2'd0, 3'd2, 1'b0, 1'b0);
          4'd3:    e = mk(2'd0, 2'd1, 2'd0, 2'd2, 3'd1, 1'b1, 1'b0);
          4'd4:    e = mk(2'd0, 2'd2, 2'd0, 2'd1, 3'd1, 1'b1, 1'b0);
          4'd5:    e = mk(2'd1, 2'd0, 2'd2, 2'd0, 3'd1, 1'b1, 1'b0);
          default: e = mk(2'd2, 2'd0, 2'd1, 2'd0, 3'd1, 1'b1, 1'b1);
        endcase
      end
      SCH_TWO_B: begin
        unique case (step)
          4'd0:    e = mk(2'd0, 2'd1, 2'd0, 2'd2, 3'd3, 1'b0, 1'b0);
          4'd1:    e = mk(2'd1, 2'd0, 2'd0, 2'd2, 3'd3, 1'b0, 1'b0);
          4'd2:    e = mk(2'd0, 2'd2, 2'd0, 2'd1, 3'd3, 1'b0, 1'b0);
          4'd3:    e = mk(2'd2, 2'd0, 2'd0, 2'd1, 3'd3, 1'b0, 1'b0);
          4'd4:    e = mk(2'd0, 2'd0, 2'd1, 2'd2, 3'd2, 1'b1, 1'b0);
          4'd5:    e = mk(2'd1, 2'd2, 2'd0, 2'd0, 3'd1, 1'b1, 1'b0);
          default: e = mk(2'd2, 2'd1, 2'd0, 2'd0, 3'd1, 1'b1, 1'b1);
        endcase
      end
      SCH_DISTINCT: begin
        unique case (step)
          4'd0:    e = mk(2'd0, 2'd1, 2'd2, 2'd3, 3'd4, 1'b0, 1'b0);
          4'd1:    e = mk(2'd1, 2'd0, 2'd2, 2'd3, 3'd4, 1'b0, 1'b0);
          4'd2:    e = mk(2'd2, 2'd3, 2'd0, 2'd1, 3'd4, 1'b0, 1'b0);
          4'd3:    e = mk(2'd3, 2'd2, 2'd0, 2'd1, 3'd4, 1'b0, 1'b0);
          4'd4:    e = mk(2'd0, 2'd2, 2'd1, 2'd3, 3'd1, 1'b1, 1'b0);
          4'd5:    e = mk(2'd1, 2'd2, 2'd0, 2'd3, 3'd1, 1'b1, 1'b0);
          4'd6:    e = mk(2'd0, 2'd3, 2'd1, 2'd2, 3'd1, 1'b1, 1'b0);
          4'd7:    e = mk(2'd1, 2'd3, 2'd0, 2'd2, 3'd1, 1'b1, 1'b0);
          4'd8:    e = mk(2'd2, 2'd0, 2'd3, 2'd1, 3'd1, 1'b1, 1'b0);
          4'd9:    e = mk(2'd2, 2'd1, 2'd3, 2'd0, 3'd1, 1'b1, 1'b0);
          4'd10:   e = mk(2'd3, 2'd0, 2'd2, 2'd1, 3'd1, 1'b1, 1'b0);
          default: e = mk(2'd3, 2'd1, 2'd2, 2'd0, 3'd1, 1'b1, 1'b1);
        endcase
      end
      default: e = mk(2'd0, 2'd0, 2'd0, 2'd0, 3'd1, 1'b0, 1'b1);
    endcase
    return e;
  endfunction

endpackage

@@ hw/rtl/fock_matrix_integral_accumulate_core.sv @@
// Top level of the Fock matrix integral accumulator: sequencer, register, ports.
// Depends on fmia_pkg, fmia_store and fmia_term_unit.
//
// Usage:
//   item/item_valid/item_ready carry one operation: load (density and core
//   element into row index_i, column index_j), integral accumulate, or read.
//   result/result_valid/result_ready return one Fock element and its saturation
//   flag for each in-range read. cfg_we/cfg_data write basis_count at once.
//   Flow: a load writes both memories before item_ready returns. A read's
//   result sits in an output register until taken. An integral runs its 1 to
//   12 updates in turn: each update fetches density and Fock words, runs the
//   shared term unit (four 32x32 partial products, weighting, rounding) and
//   writes back through the single Fock write port. Out-of-range or
//   non-canonical items are taken and dropped without a result.
//   Reset: a clearing pass zeroes every Fock word and its saturation flag; no
//   item is taken meanwhile, configuration writes still land.
//   Stall: a read waits for the output register to drain before issuing; any
//   other item runs regardless of result_ready.
module fock_matrix_integral_accumulate_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  fmia_pkg::in_item_t          item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output fmia_pkg::out_item_t         result,
  input  logic                        cfg_we,
  input  logic [fmia_pkg::CFG_W-1:0]  cfg_data
);

  localparam int IW = fmia_pkg::IDX_W;
  localparam int AW = fmia_pkg::ADDR_W;
  localparam int W  = fmia_pkg::WORD_W;

  fmia_pkg::state_t  state, state_next;
  logic [fmia_pkg::CFG_W-1:0] basis_count;
  logic [AW-1:0]     clr_cnt;

  // Latched item
  logic [IW-1:0]     row;
  logic [IW-1:0]     col;
  logic [W-1:0]      dens_val;
  logic [W-1:0]      core_val;
  logic [W-1:0]      tmag;
  logic              tsign;
  fmia_pkg::scheme_t scheme;
  logic [IW-1:0]     roles [4];
  logic [fmia_pkg::STEP_W-1:0] step;

  // Per-update registers
  logic [AW-1:0]     dst_addr;
  logic [2:0]        w_mag;
  logic              w_neg;
  logic              last;
  logic [W:0]        fock_word;

  logic              accept;
  logic              i_ok, j_ok, k_ok, l_ok, canon, go;
  fmia_pkg::scheme_t scheme_calc;
  logic [IW-1:0]     roles_calc [4];
  fmia_pkg::update_entry_t ent;

  fmia_pkg::dens_wr_t  dens_wr;
  fmia_pkg::fock_wr_t  fock_wr;
  logic [AW-1:0]       dens_raddr;
  logic [AW-1:0]       fock_raddr;
  logic [W-1:0]        dens_rdata;
  logic [W:0]          fock_rdata;
  fmia_pkg::term_req_t term_req;
  fmia_pkg::term_rsp_t term_rsp;

  logic [W-1:0]      sum;
  logic              add_ovf;
  logic [W-1:0]      sum_sat;

  assign accept = item_valid && item_ready;

  function automatic logic idx_ok(input logic [IW-1:0] x,
                                  input logic [fmia_pkg::CFG_W-1:0] n);
    return (n >= fmia_pkg::CFG_W'(fmia_pkg::MAX_BASIS)) || (fmia_pkg::CFG_W'(x) < n);
  endfunction

  // Range, canonical order and symmetry class of the offered item
  always_comb begin
    i_ok  = idx_ok(item.index_i, basis_count);
    j_ok  = idx_ok(item.index_j, basis_count);
    k_ok  = idx_ok(item.index_k, basis_count);
    l_ok  = idx_ok(item.index_l, basis_count);
    canon = (item.index_i >= item.index_j) && (item.index_k >= item.index_l) &&
            ((item.index_i > item.index_k) ||
             ((item.index_i == item.index_k) && (item.index_j >= item.index_l)));
    roles_calc[0] = item.index_i;
    roles_calc[1] = item.index_j;
    roles_calc[2] = item.index_k;
    roles_calc[3] = item.index_l;
    scheme_calc   = fmia_pkg::SCH_DISTINCT;
    priority if (item.index_i == item.index_j && item.index_k == item.index_l &&
                 item.index_i == item.index_k) begin
      scheme_calc = fmia_pkg::SCH_SINGLE;
    end else if (item.index_i == item.index_j && item.index_j == item.index_k) begin
      scheme_calc   = fmia_pkg::SCH_THREE;
      roles_calc[1] = item.index_l;
    end else if (item.index_i == item.index_j && item.index_j == item.index_l) begin
      scheme_calc   = fmia_pkg::SCH_THREE;
      roles_calc[1] = item.index_k;
    end else if (item.index_i == item.index_k && item.index_k == item.index_l) begin
      scheme_calc   = fmia_pkg::SCH_THREE;
    end else if (item.index_i == item.index_j && item.index_k == item.index_l) begin
      scheme_calc   = fmia_pkg::SCH_PAIR_A;
      roles_calc[1] = item.index_k;
    end else if (item.index_i == item.index_k && item.index_j == item.index_l) begin
      scheme_calc   = fmia_pkg::SCH_PAIR_B;
    end else if (item.index_i == item.index_j) begin
      scheme_calc   = fmia_pkg::SCH_TWO_A;
      roles_calc[1] = item.index_k;
      roles_calc[2] = item.index_l;
    end else if (item.index_k == item.index_l) begin
      scheme_calc   = fmia_pkg::SCH_TWO_A;
      roles_calc[0] = item.index_k;
      roles_calc[1] = item.index_i;
      roles_calc[2] = item.index_j;
    end else if (item.index_i == item.index_k) begin
      scheme_calc   = fmia_pkg::SCH_TWO_B;
      roles_calc[2] = item.index_l;
    end else if (item.index_j == item.index_l) begin
      scheme_calc   = fmia_pkg::SCH_TWO_B;
      roles_calc[0] = item.index_j;
      roles_calc[1] = item.index_i;
      roles_calc[2] = item.index_k;
    end else begin
      scheme_calc   = fmia_pkg::SCH_DISTINCT;
    end
    go = 1'b0;
    if (i_ok && j_ok) begin
      unique case (item.operation)
        fmia_pkg::OP_LOAD:     go = 1'b1;
        fmia_pkg::OP_INTEGRAL: go = k_ok && l_ok && canon;
        fmia_pkg::OP_READ:     go = 1'b1;
        default:               go = 1'b0;
      endcase
    end
  end

  assign ent = fmia_pkg::update_entry(scheme, step);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fmia_pkg::ST_CLEAR: begin
        if (clr_cnt == {AW{1'b1}}) state_next = fmia_pkg::ST_IDLE;
      end
      fmia_pkg::ST_IDLE: begin
        if (item_valid && go) begin
          unique case (item.operation)
            fmia_pkg::OP_LOAD:     state_next = fmia_pkg::ST_LOAD;
            fmia_pkg::OP_INTEGRAL: state_next = fmia_pkg::ST_FETCH;
            default:               state_next = fmia_pkg::ST_READ;
          endcase
        end
      end
      fmia_pkg::ST_LOAD:      state_next = fmia_pkg::ST_IDLE;
      fmia_pkg::ST_READ: begin
        if (!result_valid || result_ready) state_next = fmia_pkg::ST_READ_WAIT;
      end
      fmia_pkg::ST_READ_WAIT: state_next = fmia_pkg::ST_IDLE;
      fmia_pkg::ST_FETCH:     state_next = fmia_pkg::ST_MAG;
      fmia_pkg::ST_MAG:       state_next = fmia_pkg::ST_TERM;
      fmia_pkg::ST_TERM: begin
        if (term_rsp.done) state_next = fmia_pkg::ST_ADD;
      end
      fmia_pkg::ST_ADD: begin
        state_next = last ? fmia_pkg::ST_IDLE : fmia_pkg::ST_FETCH;
      end
      default: state_next = fmia_pkg::ST_IDLE;
    endcase
  end

  // Saturating add of the term into the Fock word
  always_comb begin
    sum     = fock_word[W-1:0] + term_rsp.term;
    add_ovf = (fock_word[W-1] == term_rsp.term[W-1]) && (sum[W-1] != fock_word[W-1]);
    if (add_ovf) begin
      sum_sat = fock_word[W-1] ? fmia_pkg::SIGN_WORD : fmia_pkg::POS_MAX;
    end else begin
      sum_sat = sum;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    item_ready    = (state == fmia_pkg::ST_IDLE);
    dens_wr.we    = (state == fmia_pkg::ST_LOAD);
    dens_wr.addr  = {row, col};
    dens_wr.data  = dens_val;
    fock_wr.we    = 1'b0;
    fock_wr.addr  = {row, col};
    fock_wr.data  = {1'b0, core_val};
    unique case (state)
      fmia_pkg::ST_CLEAR: begin
        fock_wr.we   = 1'b1;
        fock_wr.addr = clr_cnt;
        fock_wr.data = '0;
      end
      fmia_pkg::ST_LOAD: begin
        fock_wr.we   = 1'b1;
      end
      fmia_pkg::ST_ADD: begin
        fock_wr.we   = 1'b1;
        fock_wr.addr = dst_addr;
        fock_wr.data = {fock_word[W] | term_rsp.sat | add_ovf, sum_sat};
      end
      default: ;
    endcase
    dens_raddr    = {roles[ent.ps], roles[ent.qs]};
    fock_raddr    = (state == fmia_pkg::ST_READ) ? {row, col}
                                                 : {roles[ent.rs], roles[ent.cs]};
    term_req.start = (state == fmia_pkg::ST_MAG);
    term_req.dmag  = fmia_pkg::magnitude(dens_rdata);
    term_req.tmag  = tmag;
    term_req.mag   = w_mag;
    term_req.neg   = (dens_rdata[W-1] ^ tsign) ^ w_neg;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fmia_pkg::ST_CLEAR;
      clr_cnt      <= '0;
      basis_count  <= fmia_pkg::CFG_W'(fmia_pkg::MAX_BASIS);
      result_valid <= 1'b0;
      step         <= '0;
    end else begin
      state <= state_next;
      if (state == fmia_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) basis_count <= cfg_data;
      // Hold the result until transfer; a read refills only an empty slot
      if (result_valid && result_ready) result_valid <= 1'b0;
      if (state == fmia_pkg::ST_READ_WAIT) result_valid <= 1'b1;
      if (accept) step <= '0;
      else if (state == fmia_pkg::ST_ADD) step <= step + 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row      <= item.index_i;
      col      <= item.index_j;
      dens_val <= item.density_value;
      core_val <= item.core_value;
      tmag     <= fmia_pkg::magnitude(item.integral_value);
      tsign    <= item.integral_value[W-1];
      scheme   <= scheme_calc;
      for (int r = 0; r < 4; r++) roles[r] <= roles_calc[r];
    end
    if (state == fmia_pkg::ST_FETCH) begin
      dst_addr <= {roles[ent.rs], roles[ent.cs]};
      w_mag    <= ent.mag;
      w_neg    <= ent.neg;
      last     <= ent.last;
    end
    if (state == fmia_pkg::ST_MAG) fock_word <= fock_rdata;
    if (state == fmia_pkg::ST_READ_WAIT) begin
      result.fock_value <= fock_rdata[W-1:0];
      result.saturated  <= fock_rdata[W];
    end
  end

  fmia_store u_store (
    .clk        (clk),
    .dens_wr    (dens_wr),
    .dens_raddr (dens_raddr),
    .dens_rdata (dens_rdata),
    .fock_wr    (fock_wr),
    .fock_raddr (fock_raddr),
    .fock_rdata (fock_rdata)
  );

  fmia_term_unit u_term (
    .clk (clk),
    .rst (rst),
    .req (term_req),
    .rsp (term_rsp)
  );

`ifndef SYNTHESIS
  // A new result only ever follows a read issue
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == fmia_pkg::ST_READ_WAIT)
    else $error("result raised outside read path");

  // The term unit answers only while the sequencer waits for it
  a_term_done_state: assert property (@(posedge clk) disable iff (rst)
    term_rsp.done |-> state == fmia_pkg::ST_TERM)
    else $error("term unit done out of sequence");

  // Fock writes come only from clear, load or update write-back
  a_fock_write_state: assert property (@(posedge clk) disable iff (rst)
    fock_wr.we |-> (state == fmia_pkg::ST_CLEAR || state == fmia_pkg::ST_LOAD ||
                    state == fmia_pkg::ST_ADD))
    else $error("unexpected Fock write");

  // A read never issues into an occupied, stalled output register
  a_read_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == fmia_pkg::ST_READ_WAIT) |-> !result_valid)
    else $error("read result would overwrite pending result");
`endif

endmodule

@@ hw/rtl/fmia_store.sv @@
// Density and Fock memories (Fock words carry the saturation flag as top bit).
// Depends on fmia_pkg for widths and write-port structs.
module fmia_store (
  input  logic                          clk,
  input  fmia_pkg::dens_wr_t            dens_wr,
  input  logic [fmia_pkg::ADDR_W-1:0]   dens_raddr,
  output logic [fmia_pkg::WORD_W-1:0]   dens_rdata,
  input  fmia_pkg::fock_wr_t            fock_wr,
  input  logic [fmia_pkg::ADDR_W-1:0]   fock_raddr,
  output logic [fmia_pkg::WORD_W:0]     fock_rdata
);

  localparam int DEPTH = 1 << fmia_pkg::ADDR_W;

  logic [fmia_pkg::WORD_W-1:0] dens_mem [DEPTH];
  logic [fmia_pkg::WORD_W:0]   fock_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (dens_wr.we) begin
      dens_mem[dens_wr.addr] <= dens_wr.data;
    end
    dens_rdata <= dens_mem[dens_raddr];
  end

  always_ff @(posedge clk) begin
    if (fock_wr.we) begin
      fock_mem[fock_wr.addr] <= fock_wr.data;
    end
    fock_rdata <= fock_mem[fock_raddr];
  end

endmodule

@@ hw/rtl/fmia_term_unit.sv @@
// Shared term unit: |D|*|t| by four 32x32 partial products, then weight and rounding
// into qw and c, then saturation into term_q and sat_q. Depends on fmia_pkg.
module fmia_term_unit (
  input  logic                clk,
  input  logic                rst,
  input  fmia_pkg::term_req_t req,
  output fmia_pkg::term_rsp_t rsp
);

  localparam int W = fmia_pkg::WORD_W;

  logic           busy;
  logic [2:0]     cnt;
  logic [W-1:0]   a_op;
  logic [W-1:0]   b_op;
  logic [2:0]     aw;
  logic           neg;
  logic [W-1:0]   pp;
  logic [2*W-1:0] prod;
  logic [W+2:0]   qw;
  logic [2:0]     c;
  logic           ovf_hi;
  logic           done_q;
  logic [W-1:0]   term_q;
  logic           sat_q;

  logic [31:0]    a_sel;
  logic [31:0]    b_sel;
  logic [7:0]     sh;
  logic [W+2:0]   q_ext;
  logic [W+2:0]   qw_calc;
  logic [42:0]    r_ext;
  logic [42:0]    rw_calc;
  logic [42:0]    c_sum;
  logic [W+2:0]   mw;
  logic [W+2:0]   limit;
  logic           sat_calc;
  logic [W-1:0]   term_calc;

  assign a_sel = cnt[1] ? a_op[63:32] : a_op[31:0];
  assign b_sel = cnt[0] ? b_op[63:32] : b_op[31:0];

  assign rsp = '{done: done_q, term: term_q, sat: sat_q};

  always_comb begin
    unique case (cnt)
      3'd2, 3'd3: sh = 8'd32;
      3'd4:       sh = 8'd64;
      default:    sh = 8'd0;
    endcase
  end

  always_comb begin
    q_ext = {3'b000, prod[103:40]};
    r_ext = {3'b000, prod[39:0]};
    unique case (aw)
      3'd2: begin
        qw_calc = q_ext << 1;
        rw_calc = r_ext << 1;
      end
      3'd3: begin
        qw_calc = q_ext + (q_ext << 1);
        rw_calc = r_ext + (r_ext << 1);
      end
      3'd4: begin
        qw_calc = q_ext << 2;
        rw_calc = r_ext << 2;
      end
      default: begin
        qw_calc = q_ext;
        rw_calc = r_ext;
      end
    endcase
    c_sum = rw_calc + {4'b0001, 39'b0};
  end

  always_comb begin
    mw        = qw + {{W{1'b0}}, c};
    limit     = neg ? {3'b000, fmia_pkg::SIGN_WORD} : {3'b000, fmia_pkg::POS_MAX};
    sat_calc  = ovf_hi || (mw > limit);
    if (sat_calc) begin
      term_calc = neg ? fmia_pkg::SIGN_WORD : fmia_pkg::POS_MAX;
    end else begin
      term_calc = neg ? (~mw[W-1:0] + 1'b1) : mw[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd6) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      a_op <= req.dmag;
      b_op <= req.tmag;
      aw   <= req.mag;
      neg  <= req.neg;
    end
    if (busy) begin
      if (cnt <= 3'd3) begin
        pp <= {32'b0, a_sel} * {32'b0, b_sel};
      end
      if (cnt == 3'd1) begin
        prod <= {{W{1'b0}}, pp};
      end else if (cnt >= 3'd2 && cnt <= 3'd4) begin
        prod <= prod + ({{W{1'b0}}, pp} << sh);
      end
      if (cnt == 3'd5) begin
        ovf_hi <= |prod[127:103];
        qw     <= qw_calc;
        c      <= c_sum[42:40];
      end
      if (cnt == 3'd6) begin
        term_q <= term_calc;
        sat_q  <= sat_calc;
      end
    end
  end

endmodule
